// File: sv/hbtm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbtm_pkg
// Shared constants and types of the heartbeat timeout monitor: table size,
// field widths, command and status codes, and the controller/datapath links.
// ----------------------------------------------------------------------------
package hbtm_pkg;

	localparam int MAX_DEVICES = 8;
	localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int CNT_W = $clog2(MAX_DEVICES + 1);

	localparam int CMD_W    = 2;
	localparam int TYPE_W   = 4;
	localparam int INDEX_W  = 8;
	localparam int TIME_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int DEB_W    = 8;
	localparam int BLINK_W  = 16;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_REGISTER  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UPDATE    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

	localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BLINK    = 1'd1;

	localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 8'd3;
	localparam logic [BLINK_W-1:0] BLINK_RST    = 16'd250;

	typedef enum logic [1:0] {
		SEL_SINGLE = 2'd0,
		SEL_SLOT   = 2'd1,
		SEL_EMPTY  = 2'd2
	} out_sel_t;

	typedef struct packed {
		logic     load;
		logic     walk;
		logic     ptr_clr;
		logic     ptr_inc;
		logic     summary;
		logic     out_load;
		out_sel_t out_sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             hit;
		logic             ptr_last;
		logic             emit_last;
		logic             cnt_zero;
		logic             out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: sv/hbtm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbtm_ctrl
// Controller: accepts a command, walks the slot table, runs the alarm summary
// after an update and sequences the result transactions into the output stage.
// ----------------------------------------------------------------------------
module hbtm_ctrl (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic in_valid,
	output logic                     in_ready,
	input  wire hbtm_pkg::dp_stat_t  stat,
	output hbtm_pkg::ctl_cmd_t       ctl
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_WALK = 5'b00010,
		S_SUM  = 5'b00100,
		S_EMIT = 5'b01000,
		S_RESP = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ctl         = '0;
		ctl.out_sel = hbtm_pkg::SEL_SINGLE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load    = 1'b1;
					ctl.ptr_clr = 1'b1;
					state_d     = S_WALK;
				end
			end
			S_WALK: begin
				ctl.walk = 1'b1;
				// Lookups and register stop at the first slot that answers.
				if (stat.cmd != hbtm_pkg::CMD_UPDATE && stat.hit) begin
					state_d = S_RESP;
				end else if (stat.ptr_last) begin
					state_d = (stat.cmd == hbtm_pkg::CMD_UPDATE) ? S_SUM : S_RESP;
				end
			end
			S_SUM: begin
				ctl.summary = 1'b1;
				ctl.ptr_clr = 1'b1;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_sel  = stat.cnt_zero ? hbtm_pkg::SEL_EMPTY : hbtm_pkg::SEL_SLOT;
					if (stat.cnt_zero || stat.emit_last) begin
						state_d = S_IDLE;
					end else begin
						ctl.ptr_inc = 1'b1;
					end
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_sel  = hbtm_pkg::SEL_SINGLE;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: sv/hbtm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbtm_datapath
// Datapath: command registers, slot table, one slot compare/update unit that
// the controller steps through the table, alarm drive logic, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
module hbtm_datapath (
	input  wire                                    logic clk,
	input  wire                                    logic arst_n,
	input  wire hbtm_pkg::ctl_cmd_t                      ctl,
	output hbtm_pkg::dp_stat_t                           stat,
	input  wire logic [hbtm_pkg::CMD_W-1:0]              in_cmd,
	input  wire logic [hbtm_pkg::IN_DATA_W-1:0]          in_data,
	input  wire                                    logic cfg_wen,
	input  wire logic [hbtm_pkg::CFG_ADDR_W-1:0]         cfg_addr,
	input  wire logic [hbtm_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	output logic                                         out_valid,
	input  wire                                    logic out_ready,
	output logic [hbtm_pkg::STATUS_W-1:0]                out_status,
	output logic [hbtm_pkg::OUT_DATA_W-1:0]              out_data,
	output logic                                         out_last
);

	localparam int N = hbtm_pkg::MAX_DEVICES;

	// Latched command.
	logic [hbtm_pkg::CMD_W-1:0]   cmd_q;
	logic [hbtm_pkg::TYPE_W-1:0]  type_q;
	logic [hbtm_pkg::INDEX_W-1:0] idx_q;
	logic [hbtm_pkg::TIME_W-1:0]  tmo_q;
	logic [hbtm_pkg::TIME_W-1:0]  now_q;

	// Slot table.
	logic [N-1:0]                 used_q;
	logic [N-1:0]                 online_q;
	logic [hbtm_pkg::DEB_W-1:0]   miss_q   [N];
	logic [hbtm_pkg::TYPE_W-1:0]  type_mem [N];
	logic [hbtm_pkg::INDEX_W-1:0] index_mem[N];
	logic [hbtm_pkg::TIME_W-1:0]  tmo_mem  [N];
	logic [hbtm_pkg::TIME_W-1:0]  beat_mem [N];
	logic [hbtm_pkg::CNT_W-1:0]   cnt_q;

	logic [hbtm_pkg::IDX_W-1:0]   ptr_q;
	logic                         found_q;
	logic                         hit_online_q;
	logic                         all_q;

	// Alarm state.
	logic                         prev_all_q;
	logic                         phase_q;
	logic [hbtm_pkg::TIME_W-1:0]  lbt_q;
	logic                         red_q;
	logic                         green_q;
	logic                         buzz_q;

	logic [hbtm_pkg::DEB_W-1:0]   deb_q;
	logic [hbtm_pkg::BLINK_W-1:0] blink_q;

	// Slot unit.
	logic                         used_c;
	logic                         key_match;
	logic [hbtm_pkg::TIME_W-1:0]  elapsed;
	logic                         expired;
	logic [hbtm_pkg::DEB_W-1:0]   miss_cur;
	logic [hbtm_pkg::DEB_W-1:0]   miss_nxt;
	logic                         off_nxt;
	logic                         hit;
	logic                         emit_last;
	logic [hbtm_pkg::TIME_W-1:0]  blink_elapsed;
	logic                         blink_due;
	logic [hbtm_pkg::COUNT_W-1:0] count_ext;

	assign used_c    = used_q[ptr_q];
	assign key_match = (type_mem[ptr_q] == type_q) && (index_mem[ptr_q] == idx_q);
	// Elapsed time is modular, so a wrapped clock still measures correctly.
	assign elapsed   = now_q - beat_mem[ptr_q];
	assign expired   = elapsed > tmo_mem[ptr_q];
	assign miss_cur  = miss_q[ptr_q];

	always_comb begin
		if (expired) begin
			miss_nxt = (miss_cur < deb_q) ? miss_cur + hbtm_pkg::DEB_W'(1) : miss_cur;
		end else begin
			miss_nxt = '0;
		end
	end

	assign off_nxt = miss_nxt >= deb_q;

	always_comb begin
		case (cmd_q)
			hbtm_pkg::CMD_REGISTER:  hit = !used_c;
			hbtm_pkg::CMD_HEARTBEAT: hit = used_c && key_match;
			hbtm_pkg::CMD_QUERY:     hit = used_c && key_match;
			default:                 hit = 1'b0;
		endcase
	end

	assign emit_last     = (hbtm_pkg::CNT_W'(ptr_q) == cnt_q - hbtm_pkg::CNT_W'(1));
	assign blink_elapsed = now_q - lbt_q;
	assign blink_due     = blink_elapsed >= hbtm_pkg::TIME_W'(blink_q);
	assign count_ext     = hbtm_pkg::COUNT_W'(cnt_q);

	assign stat.cmd       = cmd_q;
	assign stat.hit       = hit;
	assign stat.ptr_last  = (ptr_q == hbtm_pkg::IDX_W'(N - 1));
	assign stat.emit_last = emit_last;
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.out_free  = !out_valid || out_ready;

	// Command capture and slot payload storage.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= in_cmd;
			type_q <= in_data[3:0];
			idx_q  <= in_data[11:4];
			tmo_q  <= in_data[43:12];
			now_q  <= in_data[75:44];
		end
		if (ctl.walk && hit) begin
			if (cmd_q == hbtm_pkg::CMD_REGISTER) begin
				type_mem[ptr_q]  <= type_q;
				index_mem[ptr_q] <= idx_q;
				tmo_mem[ptr_q]   <= tmo_q;
				beat_mem[ptr_q]  <= now_q;
			end else if (cmd_q == hbtm_pkg::CMD_HEARTBEAT) begin
				beat_mem[ptr_q] <= now_q;
			end
		end
	end

	// Slot flags, walk bookkeeping, alarm state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			online_q     <= '0;
			for (int i = 0; i < N; i++) begin
				miss_q[i] <= '0;
			end
			cnt_q        <= '0;
			ptr_q        <= '0;
			found_q      <= 1'b0;
			hit_online_q <= 1'b0;
			all_q        <= 1'b1;
			prev_all_q   <= 1'b1;
			phase_q      <= 1'b0;
			lbt_q        <= '0;
			red_q        <= 1'b0;
			green_q      <= 1'b0;
			buzz_q       <= 1'b0;
			deb_q        <= hbtm_pkg::DEBOUNCE_RST;
			blink_q      <= hbtm_pkg::BLINK_RST;
		end else begin
			if (cfg_wen) begin
				case (cfg_addr)
					hbtm_pkg::REG_DEBOUNCE: deb_q   <= cfg_wdata[hbtm_pkg::DEB_W-1:0];
					hbtm_pkg::REG_BLINK:    blink_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (ctl.ptr_clr) begin
				ptr_q <= '0;
			end else if (ctl.walk || ctl.ptr_inc) begin
				ptr_q <= ptr_q + hbtm_pkg::IDX_W'(1);
			end

			if (ctl.load) begin
				found_q      <= 1'b0;
				hit_online_q <= 1'b0;
				all_q        <= 1'b1;
			end

			if (ctl.walk) begin
				case (cmd_q)
					hbtm_pkg::CMD_REGISTER: begin
						if (hit) begin
							used_q[ptr_q]   <= 1'b1;
							online_q[ptr_q] <= 1'b1;
							miss_q[ptr_q]   <= '0;
							cnt_q           <= cnt_q + hbtm_pkg::CNT_W'(1);
							found_q         <= 1'b1;
							hit_online_q    <= 1'b1;
						end
					end
					hbtm_pkg::CMD_HEARTBEAT: begin
						if (hit) begin
							online_q[ptr_q] <= 1'b1;
							found_q         <= 1'b1;
							hit_online_q    <= 1'b1;
						end
					end
					hbtm_pkg::CMD_QUERY: begin
						if (hit) begin
							found_q      <= 1'b1;
							hit_online_q <= online_q[ptr_q];
						end
					end
					default: begin
						if (used_c) begin
							miss_q[ptr_q] <= miss_nxt;
							if (off_nxt) begin
								online_q[ptr_q] <= 1'b0;
								all_q           <= 1'b0;
							end else if (!online_q[ptr_q]) begin
								all_q <= 1'b0;
							end
						end
					end
				endcase
			end

			if (ctl.summary) begin
				prev_all_q <= all_q;
				if (all_q) begin
					if (!prev_all_q) begin
						red_q   <= 1'b0;
						green_q <= 1'b1;
						buzz_q  <= 1'b0;
						phase_q <= 1'b0;
					end
				end else if (prev_all_q) begin
					// First update with a device down: alarm on at once.
					red_q   <= 1'b1;
					green_q <= 1'b0;
					buzz_q  <= 1'b1;
					phase_q <= 1'b1;
					lbt_q   <= now_q;
				end else if (blink_due) begin
					lbt_q   <= now_q;
					phase_q <= !phase_q;
					red_q   <= !phase_q;
					green_q <= 1'b0;
					buzz_q  <= !phase_q;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			case (ctl.out_sel)
				hbtm_pkg::SEL_SLOT: begin
					out_status <= hbtm_pkg::ST_OK;
					out_data   <= {buzz_q, green_q, red_q, count_ext, all_q,
						online_q[ptr_q], index_mem[ptr_q], type_mem[ptr_q]};
					out_last   <= emit_last;
				end
				hbtm_pkg::SEL_EMPTY: begin
					out_status <= hbtm_pkg::ST_OK;
					out_data   <= {buzz_q, green_q, red_q, count_ext, 1'b1, 1'b0,
						hbtm_pkg::INDEX_W'(0), hbtm_pkg::TYPE_W'(0)};
					out_last   <= 1'b1;
				end
				default: begin
					if (found_q) begin
						out_status <= hbtm_pkg::ST_OK;
					end else if (cmd_q == hbtm_pkg::CMD_REGISTER) begin
						out_status <= hbtm_pkg::ST_FULL;
					end else begin
						out_status <= hbtm_pkg::ST_NOTFOUND;
					end
					out_data <= {buzz_q, green_q, red_q, count_ext, prev_all_q,
						found_q && hit_online_q, idx_q, type_q};
					out_last <= 1'b1;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/heartbeat_timeout_monitor.sv
`default_nettype none
// Register, heartbeat and query each give one result after acceptance (the slot walk
// stops at the first free or matching slot); update gives one result per used slot,
// one result per cycle while the receiver takes them.
// Throughput: one item at a time, walked one slot per cycle through the single compare
// unit; a new command is accepted only once the last result of the previous one is loaded.
// Reset (asynchronous, active low): table empty, debounce 3, blink period 250 ms.
// ----------------------------------------------------------------------------
// heartbeat_timeout_monitor
// Multi-channel heartbeat watchdog: a slot table of devices with per-device
// timeouts, debounced offline detection and a blinking alarm drive.
// ----------------------------------------------------------------------------
module heartbeat_timeout_monitor (
	input  wire                                    logic clk,
	input  wire                                    logic arst_n,
	input  wire                                    logic s_tvalid,
	output logic                                         s_tready,
	// s_tdata: dev_type[3:0], dev_index[11:4], dev_timeout[43:12], now_ms[75:44], zeros
	input  wire logic [hbtm_pkg::IN_DATA_W-1:0]          s_tdata,
	// s_tuser: cmd
	input  wire logic [hbtm_pkg::CMD_W-1:0]              s_tuser,
	output logic                                         m_tvalid,
	input  wire                                    logic m_tready,
	// m_tdata: out_type[3:0], out_index[11:4], online[12], all_up[13],
	// slot_count[20:14], led_red[21], led_green[22], buzzer[23]
	output logic [hbtm_pkg::OUT_DATA_W-1:0]              m_tdata,
	// m_tuser: status
	output logic [hbtm_pkg::STATUS_W-1:0]                m_tuser,
	output logic                                         m_tlast,
	input  wire                                    logic cfg_wen,
	input  wire logic [hbtm_pkg::CFG_ADDR_W-1:0]         cfg_addr,
	input  wire logic [hbtm_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

	hbtm_pkg::ctl_cmd_t ctl;
	hbtm_pkg::dp_stat_t stat;

	hbtm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	hbtm_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.in_cmd     (s_tuser),
		.in_data    (s_tdata),
		.cfg_wen    (cfg_wen),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_data   (m_tdata),
		.out_last   (m_tlast)
	);

endmodule
`default_nettype wire

// File: tb/heartbeat_timeout_monitor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_timeout_monitor_tb
// Self-checking testbench for the heartbeat watchdog. A scoreboard class keeps
// its own copy of the slot table, the debounce counters and the alarm drive,
// and predicts every result of each accepted command. Directed commands come
// first, then random phases under several register settings. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [hbtm_pkg::STATUS_W-1:0] status;
	logic [hbtm_pkg::TYPE_W-1:0]   out_type;
	logic [hbtm_pkg::INDEX_W-1:0]  out_index;
	logic                          online;
	logic                          all_up;
	logic [hbtm_pkg::COUNT_W-1:0]  slot_count;
	logic                          led_red;
	logic                          led_green;
	logic                          buzzer;
	logic                          last;
} slot_report_t;

class beat_scoreboard;
	logic [hbtm_pkg::DEB_W-1:0]   debounce;
	logic [hbtm_pkg::BLINK_W-1:0] blink_period;
	bit                           used [hbtm_pkg::MAX_DEVICES];
	logic [hbtm_pkg::TYPE_W-1:0]  key_type [hbtm_pkg::MAX_DEVICES];
	logic [hbtm_pkg::INDEX_W-1:0] key_index [hbtm_pkg::MAX_DEVICES];
	logic [hbtm_pkg::TIME_W-1:0]  timeout [hbtm_pkg::MAX_DEVICES];
	logic [hbtm_pkg::TIME_W-1:0]  last_beat [hbtm_pkg::MAX_DEVICES];
	bit                           online [hbtm_pkg::MAX_DEVICES];
	logic [hbtm_pkg::DEB_W-1:0]   misses [hbtm_pkg::MAX_DEVICES];
	bit                           prev_all;
	bit                           blink_on;
	logic [hbtm_pkg::TIME_W-1:0]  blink_stamp;
	bit                           red, green, buzz;
	slot_report_t                 pending_reports [$];
	int                           errors;

	function new();
		foreach (used[i]) begin
			used[i] = 0;
			online[i] = 0;
			misses[i] = '0;
		end
		prev_all = 1;
		blink_on = 0;
		blink_stamp = '0;
		{red, green, buzz} = 3'b000;
		debounce = hbtm_pkg::DEBOUNCE_RST;
		blink_period = hbtm_pkg::BLINK_RST;
		errors = 0;
	endfunction

	function void set_register(logic [hbtm_pkg::CFG_ADDR_W-1:0] addr,
			logic [hbtm_pkg::CFG_DATA_W-1:0] data);
		if (addr == hbtm_pkg::REG_DEBOUNCE)
			debounce = data[hbtm_pkg::DEB_W-1:0];
		else
			blink_period = data[hbtm_pkg::BLINK_W-1:0];
	endfunction

	function int pending();
		return pending_reports.size();
	endfunction

	function slot_report_t build(logic [hbtm_pkg::STATUS_W-1:0] st,
			logic [hbtm_pkg::TYPE_W-1:0] t, logic [hbtm_pkg::INDEX_W-1:0] x,
			bit on, bit all, bit last);
		slot_report_t r;
		int n;
		n = 0;
		foreach (used[i])
			if (used[i])
				n++;
		r.status = st;
		r.out_type = t;
		r.out_index = x;
		r.online = on;
		r.all_up = all;
		r.slot_count = n[hbtm_pkg::COUNT_W-1:0];
		r.led_red = red;
		r.led_green = green;
		r.buzzer = buzz;
		r.last = last;
		return r;
	endfunction

	function void predict_command(logic [hbtm_pkg::CMD_W-1:0] cmd,
			logic [hbtm_pkg::TYPE_W-1:0] t, logic [hbtm_pkg::INDEX_W-1:0] x,
			logic [hbtm_pkg::TIME_W-1:0] tmo, logic [hbtm_pkg::TIME_W-1:0] now);
		int hit;
		int n;
		int k;
		bit all;
		logic [hbtm_pkg::TIME_W-1:0] elapsed;
		hit = -1;
		if (cmd == hbtm_pkg::CMD_REGISTER) begin
			for (int i = 0; i < hbtm_pkg::MAX_DEVICES; i++)
				if (!used[i] && hit < 0)
					hit = i;
			if (hit < 0) begin
				pending_reports.push_back(build(hbtm_pkg::ST_FULL, t, x, 0, prev_all, 1));
			end else begin
				used[hit] = 1;
				key_type[hit] = t;
				key_index[hit] = x;
				timeout[hit] = tmo;
				last_beat[hit] = now;
				online[hit] = 1;
				misses[hit] = '0;
				pending_reports.push_back(build(hbtm_pkg::ST_OK, t, x, 1, prev_all, 1));
			end
		end else if (cmd == hbtm_pkg::CMD_HEARTBEAT || cmd == hbtm_pkg::CMD_QUERY) begin
			for (int i = 0; i < hbtm_pkg::MAX_DEVICES; i++)
				if (hit < 0 && used[i] && key_type[i] == t && key_index[i] == x)
					hit = i;
			if (hit < 0) begin
				pending_reports.push_back(build(hbtm_pkg::ST_NOTFOUND, t, x, 0,
					prev_all, 1));
			end else begin
				if (cmd == hbtm_pkg::CMD_HEARTBEAT) begin
					last_beat[hit] = now;
					online[hit] = 1;
				end
				pending_reports.push_back(build(hbtm_pkg::ST_OK, t, x, online[hit],
					prev_all, 1));
			end
		end else begin
			// Periodic update: debounce the timeouts, then refresh the alarm drive.
			for (int i = 0; i < hbtm_pkg::MAX_DEVICES; i++) begin
				if (used[i]) begin
					elapsed = now - last_beat[i];
					if (elapsed > timeout[i]) begin
						if (misses[i] < debounce)
							misses[i] = misses[i] + 8'd1;
					end else begin
						misses[i] = '0;
					end
					if (misses[i] >= debounce)
						online[i] = 0;
				end
			end
			all = 1;
			n = 0;
			foreach (used[i]) begin
				if (used[i] && !online[i])
					all = 0;
				if (used[i])
					n++;
			end
			elapsed = now - blink_stamp;
			if (all) begin
				if (!prev_all) begin
					{red, green, buzz} = 3'b010;
					blink_on = 0;
				end
			end else if (prev_all) begin
				{red, green, buzz} = 3'b101;
				blink_on = 1;
				blink_stamp = now;
			end else if (elapsed >= {16'd0, blink_period}) begin
				blink_stamp = now;
				blink_on = !blink_on;
				{red, green, buzz} = blink_on ? 3'b101 : 3'b000;
			end
			prev_all = all;
			if (n == 0) begin
				pending_reports.push_back(build(hbtm_pkg::ST_OK, '0, '0, 0, 1, 1));
			end else begin
				k = 0;
				for (int i = 0; i < hbtm_pkg::MAX_DEVICES; i++) begin
					if (used[i]) begin
						pending_reports.push_back(build(hbtm_pkg::ST_OK, key_type[i],
							key_index[i], online[i], all, k == n - 1));
						k++;
					end
				end
			end
		end
	endfunction

	task report(string msg);
		$display("[%0t] ERROR: %s", $realtime, msg);
		errors++;
	endtask

	task compare_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	task check_report(slot_report_t got);
		slot_report_t want;
		if (pending_reports.size() == 0) begin
			report($sformatf("result 0x%0h arrived with nothing expected", got));
			return;
		end
		want = pending_reports.pop_front();
		compare_field("status", got.status, want.status);
		compare_field("out_type", got.out_type, want.out_type);
		compare_field("out_index", got.out_index, want.out_index);
		compare_field("online", got.online, want.online);
		compare_field("all_up", got.all_up, want.all_up);
		compare_field("slot_count", got.slot_count, want.slot_count);
		compare_field("led_red", got.led_red, want.led_red);
		compare_field("led_green", got.led_green, want.led_green);
		compare_field("buzzer", got.buzzer, want.buzzer);
		compare_field("last", got.last, want.last);
	endtask
endclass

module heartbeat_timeout_monitor_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 23;
	localparam int PHASE_ITEMS = 21;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [hbtm_pkg::IN_DATA_W-1:0]      s_tdata;
	logic [hbtm_pkg::CMD_W-1:0]          s_tuser;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [hbtm_pkg::OUT_DATA_W-1:0]     m_tdata;
	logic [hbtm_pkg::STATUS_W-1:0]       m_tuser;
	logic                                m_tlast;
	logic                                cfg_wen;
	logic [hbtm_pkg::CFG_ADDR_W-1:0]     cfg_addr;
	logic [hbtm_pkg::CFG_DATA_W-1:0]     cfg_wdata;

	beat_scoreboard                      sb;
	bit                                  no_idle;
	logic [hbtm_pkg::TIME_W-1:0]         clock_ms;
	logic [11:0]                         known_keys [$];
	int                                  cycles;

	heartbeat_timeout_monitor u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver back-pressure, changed on the falling edge.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_report({m_tuser, m_tdata[3:0], m_tdata[11:4], m_tdata[12], m_tdata[13],
				m_tdata[20:14], m_tdata[21], m_tdata[22], m_tdata[23], m_tlast});
	end

	task automatic send_item(input logic [hbtm_pkg::CMD_W-1:0] cmd,
			input logic [hbtm_pkg::TYPE_W-1:0] t, input logic [hbtm_pkg::INDEX_W-1:0] x,
			input logic [hbtm_pkg::TIME_W-1:0] tmo, input logic [hbtm_pkg::TIME_W-1:0] now);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, now, tmo, x, t};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.predict_command(cmd, t, x, tmo, now);
	endtask

	task automatic write_reg(input logic [hbtm_pkg::CFG_ADDR_W-1:0] addr,
			input logic [hbtm_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		sb.set_register(addr, data);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (4 * (hbtm_pkg::MAX_DEVICES + 3)) @(posedge clk);
	endtask

	// Commands that walk through an empty table, duplicates, debounce into
	// offline across the time wrap, blinking, recovery and a full table.
	task automatic run_directed();
		send_item(hbtm_pkg::CMD_UPDATE, 4'd0, 8'd0, 32'd0, 32'd0);
		send_item(hbtm_pkg::CMD_QUERY, 4'd15, 8'd255, 32'hFFFF_FFFF, 32'd0);
		send_item(hbtm_pkg::CMD_HEARTBEAT, 4'd0, 8'd0, 32'd0, 32'd0);
		send_item(hbtm_pkg::CMD_REGISTER, 4'd0, 8'd0, 32'd0, 32'hFFFF_FF40);
		send_item(hbtm_pkg::CMD_REGISTER, 4'd15, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FF40);
		send_item(hbtm_pkg::CMD_REGISTER, 4'd0, 8'd0, 32'd1000, 32'hFFFF_FF40);
		send_item(hbtm_pkg::CMD_QUERY, 4'd0, 8'd0, 32'd0, 32'hFFFF_FF50);
		send_item(hbtm_pkg::CMD_UPDATE, 4'd0, 8'd0, 32'd0, 32'hFFFF_FF80);
		send_item(hbtm_pkg::CMD_UPDATE, 4'd0, 8'd0, 32'd0, 32'hFFFF_FFC0);
		send_item(hbtm_pkg::CMD_UPDATE, 4'd0, 8'd0, 32'd0, 32'h0000_0010);
		send_item(hbtm_pkg::CMD_UPDATE, 4'd0, 8'd0, 32'd0, 32'h0000_0200);
		send_item(hbtm_pkg::CMD_UPDATE, 4'd0, 8'd0, 32'd0, 32'h0000_0210);
		send_item(hbtm_pkg::CMD_QUERY, 4'd0, 8'd0, 32'd0, 32'h0000_0218);
		send_item(hbtm_pkg::CMD_HEARTBEAT, 4'd0, 8'd0, 32'd0, 32'h0000_0220);
		send_item(hbtm_pkg::CMD_UPDATE, 4'd0, 8'd0, 32'd0, 32'h0000_0220);
		send_item(hbtm_pkg::CMD_REGISTER, 4'd1, 8'd1, 32'd500, 32'h0000_0230);
		send_item(hbtm_pkg::CMD_REGISTER, 4'd2, 8'd128, 32'd500, 32'h0000_0230);
		send_item(hbtm_pkg::CMD_REGISTER, 4'd3, 8'd127, 32'd500, 32'h0000_0230);
		send_item(hbtm_pkg::CMD_REGISTER, 4'd4, 8'd64, 32'd500, 32'h0000_0230);
		send_item(hbtm_pkg::CMD_REGISTER, 4'd5, 8'd32, 32'd500, 32'h0000_0230);
		send_item(hbtm_pkg::CMD_REGISTER, 4'd6, 8'd6, 32'd500, 32'h0000_0230);
		send_item(hbtm_pkg::CMD_UPDATE, 4'd0, 8'd0, 32'd0, 32'h0000_0240);
		send_item(hbtm_pkg::CMD_HEARTBEAT, 4'd15, 8'd255, 32'd0, 32'hFFFF_FFFF);
		send_item(hbtm_pkg::CMD_UPDATE, 4'd0, 8'd0, 32'd0, 32'hFFFF_FFFF);
	endtask

	function automatic logic [11:0] pick_key();
		logic [7:0] x;
		if (known_keys.size() > 0 && $urandom_range(99) < 80)
			return known_keys[$urandom_range(known_keys.size() - 1)];
		case ($urandom_range(3))
			0: x = 8'd0;
			1: x = 8'd255;
			default: x = 8'($urandom_range(255));
		endcase
		return {x, 4'($urandom_range(15))};
	endfunction

	// Mostly commands against registered keys with a steadily advancing clock;
	// a few items carry a stray timestamp or a key that was never registered.
	task automatic run_random(input int n_items);
		logic [11:0]                 key;
		logic [hbtm_pkg::CMD_W-1:0]  cmd;
		logic [hbtm_pkg::TIME_W-1:0] tmo;
		logic [hbtm_pkg::TIME_W-1:0] now;
		int                          roll;
		for (int k = 0; k < n_items; k++) begin
			roll = $urandom_range(99);
			clock_ms = clock_ms + (($urandom_range(99) < 4) ? $urandom : $urandom_range(0, 120));
			now = ($urandom_range(99) < 5) ? $urandom : clock_ms;
			key = pick_key();
			tmo = $urandom;
			if (roll < 12) begin
				cmd = hbtm_pkg::CMD_REGISTER;
				case ($urandom_range(9))
					0: tmo = 32'd0;
					1: tmo = 32'hFFFF_FFFF;
					2: tmo = $urandom;
					default: tmo = $urandom_range(0, 300);
				endcase
				known_keys.push_back(key);
			end else if (roll < 45) begin
				cmd = hbtm_pkg::CMD_HEARTBEAT;
			end else if (roll < 57) begin
				cmd = hbtm_pkg::CMD_QUERY;
			end else begin
				cmd = hbtm_pkg::CMD_UPDATE;
			end
			send_item(cmd, key[3:0], key[11:4], tmo, now);
		end
	endtask

	initial begin
		logic [hbtm_pkg::DEB_W-1:0]   deb_set [5];
		logic [hbtm_pkg::BLINK_W-1:0] blink_set [5];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_wen = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		no_idle = 1'b0;
		cycles = 0;
		clock_ms = $urandom;
		sb = new();
		deb_set = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(1, 6)), hbtm_pkg::DEBOUNCE_RST};
		blink_set = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(1, 400)),
			hbtm_pkg::BLINK_RST};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(hbtm_pkg::REG_DEBOUNCE, {8'd0, hbtm_pkg::DEBOUNCE_RST});
		write_reg(hbtm_pkg::REG_BLINK, hbtm_pkg::BLINK_RST);
		run_directed();
		drain();

		for (int p = 0; p < 5; p++) begin
			write_reg(hbtm_pkg::REG_DEBOUNCE, {8'd0, deb_set[p]});
			write_reg(hbtm_pkg::REG_BLINK, blink_set[p]);
			no_idle = (p == 1);
			run_random(PHASE_ITEMS);
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
